>>> src/mrs_pkg.sv
`default_nettype none
package mrs_pkg;
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_COLUMNS = 4096;
    localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S24_MIN = -24'sh800000;
    localparam logic [22:0] STD_MAX = 23'h7FFFFF;

    localparam logic [0:0] ADDR_BEAM = 1'b0;
    localparam logic [0:0] ADDR_BAD  = 1'b1;

    localparam logic [2:0] BEAM_RESET = 3'd1;

    function automatic logic [2:0] beam_of(input logic [7:0] code);
        logic [2:0] b;
        begin
            case (code)
                8'd1:    b = 3'd1;
                8'd2:    b = 3'd2;
                8'd4:    b = 3'd3;
                8'd8:    b = 3'd4;
                8'd16:   b = 3'd5;
                default: b = 3'd0;
            endcase
            return b;
        end
    endfunction
endpackage
`default_nettype wire

>>> src/mrs_mathseq.sv
`default_nettype none
// Row finish math: one 32x32 multiplier reused for the 64-bit products, then
// bit-serial division (128 steps) and square root (32 steps), then mean division.
module mrs_mathseq import mrs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [35:0] i_sum,
    input  wire logic [59:0]        i_sq,
    input  wire logic [12:0]        i_n,
    output logic                    o_done,
    output logic signed [23:0]      o_mean,
    output logic [31:0]             o_sd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_MEAN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]   r_st;
    logic [2:0]   r_mstep;
    logic [6:0]   r_cnt;
    logic [127:0] r_acc;
    logic [127:0] r_num;
    logic [63:0]  r_a, r_b;
    logic [63:0]  r_rem, r_q, r_d;
    logic [31:0]  r_res;
    logic [35:0]  r_asum;
    logic         r_neg;
    logic [35:0]  r_mq;
    logic [12:0]  r_n;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_p;
    logic [1:0]  w_i, w_j;
    assign w_i  = r_mstep[1] ? 2'd1 : 2'd0;
    assign w_j  = r_mstep[0] ? 2'd1 : 2'd0;
    assign w_ma = w_i[0] ? r_a[63:32] : r_a[31:0];
    assign w_mb = w_j[0] ? r_b[63:32] : r_b[31:0];
    assign w_p  = w_ma * w_mb;

    logic [64:0] w_rs;
    logic [64:0] w_rsub;
    logic [65:0] w_trial;
    logic [66:0] w_sub;
    logic [36:0] w_mrem;
    logic [36:0] w_msub;

    assign w_rs   = {r_rem, r_num[127]};
    assign w_rsub = w_rs - {1'b0, r_d};
    // sqrt: two bits of remainder per step
    assign w_trial = {r_rem, r_acc[63:62]};
    assign w_sub   = {1'b0, w_trial} - {33'd0, r_res, 2'b01};
    assign w_mrem  = {r_rem[35:0], r_asum[35]};
    assign w_msub  = w_mrem - {24'd0, r_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_st    <= S_MUL;
                        r_mstep <= 3'd0;
                        r_a     <= {51'd0, i_n};
                        r_b     <= {4'd0, i_sq};
                        r_acc   <= '0;
                        r_n     <= i_n;
                        r_neg   <= i_sum[35];
                        r_asum  <= i_sum[35] ? -i_sum : i_sum;
                        r_d     <= {38'd0, 26'(i_n) * 26'(i_n - 13'd1)};
                    end
                end
                S_MUL: begin
                    // steps 0-3: n*sq, steps 4-7: |sum|^2 subtracted
                    if (r_mstep[2])
                        r_acc <= r_acc - ({64'd0, w_p} << (32 * (w_i + w_j)));
                    else
                        r_acc <= r_acc + ({64'd0, w_p} << (32 * (w_i + w_j)));
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep == 3'd3) begin
                        r_a <= {28'd0, r_asum};
                        r_b <= {28'd0, r_asum};
                    end
                    if (r_mstep == 3'd7) begin
                        r_st  <= S_DIV;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_q   <= '0;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd0 && r_rem == 64'd0 && r_q == 64'd0)
                        r_num <= r_acc;
                    if (!(r_cnt == 7'd0 && r_rem == 64'd0 && r_q == 64'd0 &&
                          r_num != r_acc)) begin
                        r_num <= r_num << 1;
                        if (!w_rsub[64]) begin
                            r_rem <= w_rsub[63:0];
                            r_q   <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= w_rs[63:0];
                            r_q   <= {r_q[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'd127) r_st <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == 7'd0) begin
                        r_acc <= {64'd0, r_q};
                        r_rem <= '0;
                        r_res <= '0;
                        r_cnt <= 7'd1;
                    end else begin
                        r_acc <= r_acc << 2;
                        if (!w_sub[66]) begin
                            r_rem <= w_sub[63:0];
                            r_res <= {r_res[30:0], 1'b1};
                        end else begin
                            r_rem <= w_trial[63:0];
                            r_res <= {r_res[30:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'd32) begin
                            r_st  <= S_MEAN;
                            r_cnt <= '0;
                            r_rem <= '0;
                        end
                    end
                end
                S_MEAN: begin
                    r_asum <= r_asum << 1;
                    if (!w_msub[36]) begin
                        r_rem <= {28'd0, w_msub[35:0]};
                        r_mq  <= {r_mq[34:0], 1'b1};
                    end else begin
                        r_rem <= {28'd0, w_mrem[35:0]};
                        r_mq  <= {r_mq[34:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd35) r_st <= S_DONE;
                end
                S_DONE: r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    logic [35:0] w_m;
    assign w_m    = r_neg ? -r_mq : r_mq;
    assign o_done = (r_st == S_DONE);
    assign o_mean = w_m[23:0];
    assign o_sd   = r_res;

    a_mean_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_MEAN) |-> (r_n >= 13'd2)) else $error("divide with count below two");
    a_mul_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_MUL) |-> (r_mstep <= 3'd7)) else $error("bad product step");
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_st == S_DONE)) else $error("done outside done state");
endmodule
`default_nettype wire

>>> src/masked_row_statistics.sv
`default_nettype none
// channel | handshake          | word
// in      | i_valid / o_stall  | sample_value, beam_code, last_in_row
// out     | o_valid / i_stall  | row statistics
// cfg     | APB psel/penable   | selected_beam, bad_value_code
// A sample that does not close a row only updates the row accumulators.
// A row end with two or more kept samples runs the shared math sequencer:
// 8 multiply steps, a load and 128 divide steps, a load and the root steps, 36 mean
// steps and a done state; the result is then registered at the outputs with o_valid.
// The input stalls while the math runs and while a result is held under output stall.
// Reset is synchronous, active low; no clearing pass.
module masked_row_statistics import mrs_pkg::*; #(
    parameter int ROW_INDEX_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [23:0] i_sample_value,
    input  wire logic [7:0]         i_beam_code,
    input  wire logic               i_last_in_row,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_row_index,
    output logic signed [23:0]      o_row_mean,
    output logic signed [23:0]      o_mean_minus_std,
    output logic signed [23:0]      o_mean_plus_std,
    output logic signed [23:0]      o_row_min,
    output logic signed [23:0]      o_row_max,
    output logic [22:0]             o_row_std,
    output logic [12:0]             o_sample_count,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [2:0]          r_beam;
    logic signed [23:0]  r_bad;
    logic signed [35:0]  r_sum;
    logic [59:0]         r_sq;
    logic [12:0]         r_cnt;
    logic signed [23:0]  r_min, r_max;
    logic [ROW_INDEX_BITS-1:0] r_row;
    logic                r_busy;
    logic [15:0]         r_hidx;
    logic signed [23:0]  r_hmin, r_hmax;
    logic [12:0]         r_hcnt;

    logic               w_done;
    logic signed [23:0] w_mean;
    logic [31:0]        w_sd;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            ADDR_BEAM: prdata = {29'd0, r_beam};
            default:   prdata = {{8{r_bad[23]}}, r_bad};
        endcase
    end

    logic w_acc, w_keep, w_fin;
    assign o_stall = r_busy || (o_valid && i_stall);
    assign w_acc   = i_valid && !o_stall;
    assign w_keep  = (i_sample_value != r_bad) && (beam_of(i_beam_code) == r_beam)
                     && ({19'd0, r_cnt} < 32'(MAX_COLUMNS));

    logic [12:0]        w_ncnt;
    logic signed [35:0] w_nsum;
    logic [59:0]        w_nsq;
    logic signed [23:0] w_nmin, w_nmax;
    logic signed [47:0] w_x2;
    assign w_x2   = i_sample_value * i_sample_value;
    assign w_ncnt = w_keep ? r_cnt + 13'd1 : r_cnt;
    assign w_nsum = w_keep ? r_sum + 36'(i_sample_value) : r_sum;
    assign w_nsq  = w_keep ? r_sq + {12'd0, w_x2} : r_sq;
    assign w_nmin = (w_keep && i_sample_value < r_min) ? i_sample_value : r_min;
    assign w_nmax = (w_keep && i_sample_value > r_max) ? i_sample_value : r_max;
    assign w_fin  = w_acc && i_last_in_row && (w_ncnt >= 13'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam  <= BEAM_RESET;
            r_bad   <= S24_MIN;
            r_sum   <= '0;
            r_sq    <= '0;
            r_cnt   <= '0;
            r_min   <= S24_MAX;
            r_max   <= S24_MIN;
            r_row   <= '0;
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == ADDR_BAD) r_bad <= pwdata[23:0];
                else if (paddr == 3'd0) r_beam <= pwdata[2:0];
            end
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (w_acc) begin
                if (i_last_in_row) begin
                    r_sum <= '0;
                    r_sq  <= '0;
                    r_cnt <= '0;
                    r_min <= S24_MAX;
                    r_max <= S24_MIN;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_sum <= w_nsum;
                    r_sq  <= w_nsq;
                    r_cnt <= w_ncnt;
                    r_min <= w_nmin;
                    r_max <= w_nmax;
                end
            end
            if (w_fin) r_busy <= 1'b1;
            if (w_done) begin
                r_busy  <= 1'b0;
                o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_hidx <= 16'(r_row);
            r_hmin <= w_nmin;
            r_hmax <= w_nmax;
            r_hcnt <= w_ncnt;
        end
    end

    mrs_mathseq u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fin),
        .i_sum   (w_nsum),
        .i_sq    (w_nsq),
        .i_n     (w_ncnt),
        .o_done  (w_done),
        .o_mean  (w_mean),
        .o_sd    (w_sd)
    );

    logic signed [33:0] w_lo, w_hi;
    assign w_lo = 34'(w_mean) - $signed({2'b0, w_sd});
    assign w_hi = 34'(w_mean) + $signed({2'b0, w_sd});

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            o_row_index      <= r_hidx;
            o_row_mean       <= w_mean;
            o_row_min        <= r_hmin;
            o_row_max        <= r_hmax;
            o_sample_count   <= r_hcnt;
            o_row_std        <= (w_sd > 32'(STD_MAX)) ? STD_MAX : w_sd[22:0];
            o_mean_minus_std <= (w_lo < 34'(S24_MIN)) ? S24_MIN : w_lo[23:0];
            o_mean_plus_std  <= (w_hi > 34'(S24_MAX)) ? S24_MAX : w_hi[23:0];
        end
    end

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_stall) else $error("accepted while busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy) else $error("result without row end");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |-> !(o_valid && i_stall)) else $error("result register overrun");
endmodule
`default_nettype wire

>>> test/masked_row_statistics_tb.sv
`default_nettype none
module masked_row_statistics_tb;
    import mrs_pkg::*;

    typedef struct packed {
        logic signed [23:0] value;
        logic [7:0]         code;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic [15:0]        row_index;
        logic signed [23:0] mean;
        logic signed [23:0] lo_band;
        logic signed [23:0] hi_band;
        logic signed [23:0] min_v;
        logic signed [23:0] max_v;
        logic [22:0]        std_v;
        logic [12:0]        count;
    } row_stats_t;

    localparam int MAX_COLS  = 4096;
    localparam int LIMIT     = 2000000;
    localparam int MATH_GAP  = 260;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [23:0] i_sample_value = '0;
    logic [7:0] i_beam_code = '0;
    logic i_last_in_row = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [15:0] o_row_index;
    logic signed [23:0] o_row_mean, o_mean_minus_std, o_mean_plus_std, o_row_min, o_row_max;
    logic [22:0] o_row_std;
    logic [12:0] o_sample_count;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    masked_row_statistics u_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [2:0]          sel_beam;
    logic signed [23:0]  bad_code;
    logic signed [35:0]  acc_sum;
    logic [59:0]         acc_sq;
    int unsigned         acc_n;
    logic signed [23:0]  acc_min, acc_max;
    logic [15:0]         row_num;

    sample_t    pending_words[$];
    row_stats_t expected_rows[$];
    int  errors = 0;
    int  rows_seen = 0;
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  hold_rx = 1'b0;
    int  tx_idle = 0;
    int  rx_idle = 0;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [23:0] clamp24(input logic signed [63:0] v);
        if (v > 64'sd8388607) return S24_MAX;
        if (v < -64'sd8388608) return S24_MIN;
        return v[23:0];
    endfunction

    task automatic clear_accum();
        acc_sum = '0;
        acc_sq = '0;
        acc_n = 0;
        acc_min = S24_MAX;
        acc_max = S24_MIN;
    endtask

    task automatic predict_stats(input sample_t s);
        logic [2:0] b;
        logic [127:0] num, nsq, abss;
        logic [63:0] var_v, sd, dn;
        logic signed [63:0] mean, sum64, xv;
        row_stats_t r;
        b = (s.code == 8'd1) ? 3'd1 : (s.code == 8'd2) ? 3'd2 : (s.code == 8'd4) ? 3'd3 :
            (s.code == 8'd8) ? 3'd4 : (s.code == 8'd16) ? 3'd5 : 3'd0;
        if (s.value != bad_code && b == sel_beam && acc_n < MAX_COLS) begin
            xv = s.value;
            acc_sum = acc_sum + s.value;
            acc_sq = acc_sq + 60'(xv * xv);
            acc_n++;
            if (s.value > acc_max) acc_max = s.value;
            if (s.value < acc_min) acc_min = s.value;
        end
        if (!s.last) return;
        if (acc_n >= 2) begin
            sum64 = acc_sum;
            abss = (sum64 < 0) ? 128'(-sum64) : 128'(sum64);
            nsq = 128'(acc_n) * 128'(acc_sq);
            num = nsq - abss * abss;
            dn = 64'(acc_n) * 64'(acc_n - 1);
            var_v = 64'(num / 128'(dn));
            sd = isqrt(var_v);
            mean = sum64 / $signed(64'(acc_n));
            r.row_index = row_num;
            r.mean = mean[23:0];
            r.lo_band = clamp24(mean - $signed(sd));
            r.hi_band = clamp24(mean + $signed(sd));
            r.min_v = acc_min;
            r.max_v = acc_max;
            r.std_v = (sd > 64'd8388607) ? STD_MAX : sd[22:0];
            r.count = acc_n[12:0];
            expected_rows.push_back(r);
        end
        row_num = row_num + 16'd1;
        clear_accum();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("row %0d: %s got %0h want %0h", rows_seen, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) predict_stats({i_sample_value, i_beam_code, i_last_in_row});
                if (tx_idle > 0) begin
                    tx_idle <= tx_idle - 1;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0 && !calm && $urandom_range(0, 9) == 0)
                begin
                    tx_idle <= $urandom_range(0, 2);
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_valid <= 1'b1;
                    {i_sample_value, i_beam_code, i_last_in_row} <= pending_words.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        row_stats_t w;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            rows_seen++;
            if (expected_rows.size() == 0) begin
                report_mismatch("unexpected row", o_row_index, 0);
            end else begin
                w = expected_rows.pop_front();
                if (o_row_index != w.row_index) report_mismatch("index", o_row_index, w.row_index);
                if (o_row_mean != w.mean) report_mismatch("mean", o_row_mean, w.mean);
                if (o_mean_minus_std != w.lo_band)
                    report_mismatch("mean-std", o_mean_minus_std, w.lo_band);
                if (o_mean_plus_std != w.hi_band)
                    report_mismatch("mean+std", o_mean_plus_std, w.hi_band);
                if (o_row_min != w.min_v) report_mismatch("min", o_row_min, w.min_v);
                if (o_row_max != w.max_v) report_mismatch("max", o_row_max, w.max_v);
                if (o_row_std != w.std_v) report_mismatch("std", o_row_std, w.std_v);
                if (o_sample_count != w.count) report_mismatch("count", o_sample_count, w.count);
            end
        end
        if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (rx_idle > 0) begin
            rx_idle <= rx_idle - 1;
            i_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rx_idle <= $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'(ADDR_BEAM * 4)) sel_beam = data[2:0];
        else bad_code = data[23:0];
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || i_valid || expected_rows.size() > 0)
            @(posedge i_clk);
        repeat (MATH_GAP) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_code(input logic [2:0] beam);
        case ($urandom_range(0, 9))
            0: return 8'($urandom);
            1: return 8'd0;
            default: begin
                if (beam >= 1 && beam <= 5) return 8'd1 << (beam - 1);
                if (beam == 0) return 8'($urandom_range(17, 255));
                return 8'(1 << $urandom_range(0, 4));
            end
        endcase
    endfunction

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(0, 5))
            0: return S24_MAX;
            1: return S24_MIN;
            2: return 24'($urandom_range(0, 400)) - 24'sd200;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic queue_row(input int len, input logic [2:0] beam);
        sample_t s;
        for (int k = 0; k < len; k++) begin
            s.value = pick_value();
            if ($urandom_range(0, 30) == 0) s.value = bad_code;
            s.code = pick_code(beam);
            s.last = (k == len - 1);
            pending_words.push_back(s);
        end
    endtask

    initial begin
        int hold_len;
        sel_beam = BEAM_RESET;
        bad_code = S24_MIN;
        row_num = '0;
        clear_accum();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, bad code at reset, short rows, wide deviation
        pending_words.push_back('{S24_MAX, 8'd1, 1'b0});
        pending_words.push_back('{S24_MIN, 8'd1, 1'b0});
        pending_words.push_back('{24'sd5, 8'd1, 1'b0});
        pending_words.push_back('{S24_MIN + 24'sd1, 8'd1, 1'b1});
        pending_words.push_back('{24'sd7, 8'd1, 1'b1});
        pending_words.push_back('{24'sd7, 8'd2, 1'b0});
        pending_words.push_back('{24'sd3, 8'd1, 1'b0});
        pending_words.push_back('{-24'sd3, 8'd1, 1'b1});
        pending_words.push_back('{S24_MAX, 8'd1, 1'b0});
        pending_words.push_back('{S24_MAX, 8'd1, 1'b1});
        pending_words.push_back('{24'sd1, 8'hFF, 1'b1});
        drain();
        write_reg(3'(ADDR_BEAM * 4), 32'd0);
        write_reg(3'(ADDR_BAD * 4), 32'h007FFFFF);
        pending_words.push_back('{S24_MAX, 8'd0, 1'b0});
        pending_words.push_back('{24'sd9, 8'd3, 1'b0});
        pending_words.push_back('{-24'sd9, 8'hA0, 1'b0});
        pending_words.push_back('{24'sd1, 8'd16, 1'b1});
        drain();
        write_reg(3'(ADDR_BEAM * 4), 32'd6);
        queue_row(4, 3'd6);
        drain();

        // random phases across beam settings 0 to 5 and 7
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(3'(ADDR_BEAM * 4), (ph == 7) ? 32'd7 : 32'(ph % 6));
            write_reg(3'(ADDR_BAD * 4), (ph % 3 == 0) ? 32'h00800000 : $urandom);
            if (ph == 6) calm = 1'b1;
            for (int r = 0; r < 20; r++) queue_row($urandom_range(1, 14), sel_beam);
            if (ph == 2) begin
                // stall the receiver for a long stretch while rows keep arriving
                hold_rx = 1'b1;
                hold_len = 0;
                while (hold_len < 600) begin
                    @(posedge i_clk);
                    hold_len++;
                end
                hold_rx = 1'b0;
            end
            drain();
        end

        $display("covered %0d result rows over %0d input rows, all beam selectors",
                 rows_seen, row_num);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
